### rtl/core/ckb_pkg.sv
`default_nettype none
package ckb_pkg;

   localparam int KEY_W       = 41;
   localparam int KEY_REGS    = 3;
   localparam int CENTRE_W    = 9;
   localparam int LEN_W       = 11;
   localparam int DIST_W      = 18;  // sqrt of d2<<16, d2 < 2^19
   localparam int ALPHA_W     = 9;
   localparam int SQ_STEPS    = 18;  // result bits of the root
   localparam int DIV_STEPS   = 9;   // quotient bits, q <= 256

   localparam logic [ALPHA_W-1:0] ALPHA_FULL = 9'd256;

   typedef struct packed {
      logic                enable;
      logic [CENTRE_W-1:0] cu;
      logic [CENTRE_W-1:0] cv;
      logic [LEN_W-1:0]    radius;
      logic [LEN_W-1:0]    slope;
   } key_type;

   typedef struct packed {
      logic [7:0] fg_luma_tl;
      logic [7:0] fg_luma_tr;
      logic [7:0] fg_luma_bl;
      logic [7:0] fg_luma_br;
      logic [7:0] bg_luma_tl;
      logic [7:0] bg_luma_tr;
      logic [7:0] bg_luma_bl;
      logic [7:0] bg_luma_br;
      logic [7:0] fg_cb;
      logic [7:0] fg_cr;
      logic [7:0] bg_cb;
      logic [7:0] bg_cr;
   } quad_type;

   // one output pixel of the blend: (fg*(256-a)+bg*a)>>8
   function automatic logic [7:0] mix(input logic [7:0] fg, input logic [7:0] bg,
                                      input logic [ALPHA_W-1:0] a);
      logic [16:0] acc;
      acc = 17'(fg) * 17'(ALPHA_FULL - a) + 17'(bg) * 17'(a);
      return acc[15:8];
   endfunction

endpackage
`default_nettype wire

### rtl/core/ckb_lane.sv
`default_nettype none
// One key: pipelined restoring square root then restoring division.
// Fully pipelined, one quad per cycle while adv is high; alpha comes 32 register stages
// after u, v and the key are taken.
module ckb_lane (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire ckb_pkg::key_type              key,
   input  wire logic [7:0]                    u,
   input  wire logic [7:0]                    v,
   output      logic [ckb_pkg::ALPHA_W-1:0]   alpha
);
   localparam int SQ = ckb_pkg::SQ_STEPS;
   localparam int DV = ckb_pkg::DIV_STEPS;
   localparam int DW = ckb_pkg::DIST_W;
   localparam int RW = 2 * DW + 2;  // radicand / remainder width
   localparam int LW = ckb_pkg::LEN_W + 5;

   // stages 0 and 1: offsets, then their squares
   logic [8:0]  du_ff, dv_ff;
   logic [17:0] du2_ff, dv2_ff;
   logic        en0_ff, en1_ff;
   logic [LW-1:0] rad0_ff, slp0_ff, rad1_ff, slp1_ff;

   logic [8:0] du_in, dv_in;
   always_comb begin
      du_in = (key.cu > {1'b0, u}) ? key.cu - {1'b0, u} : {1'b0, u} - key.cu;
      dv_in = (key.cv > {1'b0, v}) ? key.cv - {1'b0, v} : {1'b0, v} - key.cv;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         du_ff   <= du_in;
         dv_ff   <= dv_in;
         en0_ff  <= key.enable;
         rad0_ff <= {key.radius, 5'd0};
         slp0_ff <= {key.slope, 5'd0};
         du2_ff  <= du_ff * du_ff;
         dv2_ff  <= dv_ff * dv_ff;
         en1_ff  <= en0_ff;
         rad1_ff <= rad0_ff;
         slp1_ff <= slp0_ff;
      end
   end

   // square root, one result bit per stage
   logic [RW-1:0] sx_ff [SQ+1];
   logic [RW-1:0] sr_ff [SQ+1];
   logic [DW-1:0] sq_ff [SQ+1];
   logic          sen_ff [SQ+1];
   logic [LW-1:0] srad_ff [SQ+1];
   logic [LW-1:0] sslp_ff [SQ+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         sx_ff[0]   <= ((RW)'(du2_ff) + (RW)'(dv2_ff)) << 16;
         sr_ff[0]   <= '0;
         sq_ff[0]   <= '0;
         sen_ff[0]  <= en1_ff;
         srad_ff[0] <= rad1_ff;
         sslp_ff[0] <= slp1_ff;
      end
   end

   // radicand sits in the low 2*SQ bits; pairs taken from bit 2*SQ-1 down
   for (genvar s = 0; s < SQ; s++) begin : g_sq
      logic [RW-1:0] rem_w, trial_w;
      always_comb begin
         rem_w   = {sr_ff[s][RW-3:0], sx_ff[s][2*SQ-1 -: 2]};
         trial_w = {(RW-DW-2)'(0), sq_ff[s], 2'b01};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sx_ff[s+1]   <= sx_ff[s] << 2;
            if (rem_w >= trial_w) begin
               sr_ff[s+1] <= rem_w - trial_w;
               sq_ff[s+1] <= {sq_ff[s][DW-2:0], 1'b1};
            end else begin
               sr_ff[s+1] <= rem_w;
               sq_ff[s+1] <= {sq_ff[s][DW-2:0], 1'b0};
            end
            sen_ff[s+1]  <= sen_ff[s];
            srad_ff[s+1] <= srad_ff[s];
            sslp_ff[s+1] <= sslp_ff[s];
         end
      end
   end

   // classify: full, zero or divide
   logic [DW-1:0] dist_w;
   logic [DW:0]   diff_w;
   logic [1:0]    cls_in;
   localparam logic [1:0] CLS_ZERO = 2'd0, CLS_FULL = 2'd1, CLS_DIV = 2'd2;
   always_comb begin
      dist_w = sq_ff[SQ];
      diff_w = {1'b0, dist_w} - (DW+1)'(srad_ff[SQ]);
      if (!sen_ff[SQ])                          cls_in = CLS_ZERO;
      else if ((DW+1)'(dist_w) <= (DW+1)'(srad_ff[SQ])) cls_in = CLS_FULL;
      else if (sslp_ff[SQ] == '0 || diff_w > (DW+1)'(sslp_ff[SQ])) cls_in = CLS_ZERO;
      else                                      cls_in = CLS_DIV;
   end

   // division: ceil(diff*256/slope); diff <= slope so q <= 256
   localparam int NW = LW + 1;
   logic [1:0]    dcls_ff [DV+1];
   logic [NW-1:0] drem_ff [DV+1];
   logic [DV-1:0] dq_ff   [DV+1];
   logic [LW-1:0] dslp_ff [DV+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         dcls_ff[0] <= cls_in;
         drem_ff[0] <= NW'(diff_w);
         dq_ff[0]   <= '0;
         dslp_ff[0] <= sslp_ff[SQ];
      end
   end

   // first step compares diff itself (quotient bit 8), then shifts in zeros
   for (genvar s = 0; s < DV; s++) begin : g_dv
      logic [NW-1:0] r_w;
      always_comb r_w = (s == 0) ? drem_ff[s] : {drem_ff[s][NW-2:0], 1'b0};
      always_ff @(posedge clock) begin
         if (adv) begin
            if (r_w >= NW'(dslp_ff[s])) begin
               drem_ff[s+1] <= r_w - NW'(dslp_ff[s]);
               dq_ff[s+1]   <= {dq_ff[s][DV-2:0], 1'b1};
            end else begin
               drem_ff[s+1] <= r_w;
               dq_ff[s+1]   <= {dq_ff[s][DV-2:0], 1'b0};
            end
            dcls_ff[s+1] <= dcls_ff[s];
            dslp_ff[s+1] <= dslp_ff[s];
         end
      end
   end

   logic [ckb_pkg::ALPHA_W-1:0] alpha_ff, alpha_in, q_w;
   always_comb begin
      q_w = dq_ff[DV] + ((drem_ff[DV] != '0) ? 9'd1 : 9'd0);
      case (dcls_ff[DV])
         CLS_FULL: alpha_in = ckb_pkg::ALPHA_FULL;
         CLS_DIV:  alpha_in = ckb_pkg::ALPHA_FULL - q_w;
         default:  alpha_in = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (adv) alpha_ff <= alpha_in;
   end
   assign alpha = alpha_ff;

endmodule
`default_nettype wire

### rtl/core/ckb_merge.sv
`default_nettype none
// Largest lane alpha, then the six blends, registered.
module ckb_merge #(
   parameter int NUM_KEYS = 3
) (
   input  wire logic                                 clock,
   input  wire logic                                 adv,
   input  wire logic [NUM_KEYS*ckb_pkg::ALPHA_W-1:0] lane_alpha,
   input  wire ckb_pkg::quad_type                    quad,
   output      logic [63:0]                          data
);
   localparam int AW = ckb_pkg::ALPHA_W;
   logic [AW-1:0] a_w;
   logic [63:0]   data_ff;

   always_comb begin
      a_w = '0;
      for (int i = 0; i < NUM_KEYS; i++)
         if (lane_alpha[i*AW +: AW] > a_w) a_w = lane_alpha[i*AW +: AW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= {7'd0, a_w,
                     ckb_pkg::mix(quad.fg_cr, quad.bg_cr, a_w),
                     ckb_pkg::mix(quad.fg_cb, quad.bg_cb, a_w),
                     ckb_pkg::mix(quad.fg_luma_br, quad.bg_luma_br, a_w),
                     ckb_pkg::mix(quad.fg_luma_bl, quad.bg_luma_bl, a_w),
                     ckb_pkg::mix(quad.fg_luma_tr, quad.bg_luma_tr, a_w),
                     ckb_pkg::mix(quad.fg_luma_tl, quad.bg_luma_tl, a_w)};
      end
   end
   assign data = data_ff;
endmodule
`default_nettype wire

### rtl/core/chroma_key_blend.sv
`default_nettype none
// Soft chroma key and alpha blend over one 4:2:0 quad per word. Fully
// pipelined: one quad per cycle sustained while not stalled; the result word
// passes through 33 register stages from acceptance (two of squaring,
// the radicand register, 18 square-root stages, 10 divide stages, one lane
// register, one blend register). The pipeline advances whenever the output
// register is empty or being taken, so req_tready = rsp_tready || !rsp_tvalid.
// Key registers take effect on items accepted after the write.
module chroma_key_blend #(
   parameter int NUM_KEYS = 3
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [40:0]  csr_wdata,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   // fg_luma_tl,tr,bl,br, bg_luma_tl,tr,bl,br, fg_cb, fg_cr, bg_cb, bg_cr
   input  wire logic [95:0]  req_tdata,
   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // out_luma_tl,tr,bl,br, out_cb, out_cr, alpha, 7 zero bits
   output      logic [63:0]  rsp_tdata
);
   // register stages inside a lane, entry to alpha
   localparam int LAT = 3 + ckb_pkg::SQ_STEPS + 1 + ckb_pkg::DIV_STEPS + 1;
   localparam int AW  = ckb_pkg::ALPHA_W;

   ckb_pkg::key_type key_ff [NUM_KEYS];
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (reset) key_ff[i] <= '0;
         else if (csr_we && i < ckb_pkg::KEY_REGS && 32'(csr_index) == i)
            key_ff[i] <= csr_wdata;
      end
   end

   logic adv;
   assign adv = rsp_tready || !rsp_tvalid;
   assign req_tready = adv;

   ckb_pkg::quad_type quad_w;
   always_comb quad_w = {<<8{req_tdata}};

   logic [LAT-1:0]    vld_ff;
   ckb_pkg::quad_type qd_ff [LAT];
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         qd_ff[0] <= quad_w;
         for (int i = 1; i < LAT; i++) qd_ff[i] <= qd_ff[i-1];
      end
   end

   logic [NUM_KEYS*AW-1:0] lane_alpha;
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
      ckb_lane u_lane (
         .clock (clock), .adv (adv), .key (key_ff[k]),
         .u (quad_w.fg_cb), .v (quad_w.fg_cr),
         .alpha (lane_alpha[k*AW +: AW]));
   end

   // lanes register u,v at entry; quad at stage LAT-1 lines up with lane output
   ckb_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
      .clock (clock), .adv (adv), .lane_alpha (lane_alpha),
      .quad (qd_ff[LAT-1]), .data (rsp_tdata));

   logic rv_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (adv) rv_ff <= vld_ff[LAT-1];
   end
   assign rsp_tvalid = rv_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output lost while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("stalled with empty output");
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[56:48] <= 9'd256)
      else $error("alpha out of range");
endmodule
`default_nettype wire

### tb/sv/tb_chroma_key_blend.sv
`timescale 1ns / 1ps
module tb_chroma_key_blend;

   localparam int CSR_KEY_ONE   = 0;
   localparam int CSR_KEY_TWO   = 1;
   localparam int CSR_KEY_THREE = 2;
   localparam int CSR_UNUSED    = 3;
   localparam int LATENCY       = 33;
   localparam int N_RANDOM      = 1300;

   typedef struct {
      logic [7:0] luma [4];
      logic [7:0] cb;
      logic [7:0] cr;
      logic [8:0] alpha;
   } blend_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [40:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;

   logic [40:0]  key_shadow [3];
   blend_t       blend_queue [$];
   logic [64:0]  typed_queue [$];  // bit 64: result typed in
   int           mismatches = 0;
   int           words_in = 0;
   int           words_out = 0;
   int           keyed_full = 0;
   int           keyed_soft = 0;
   bit           calm = 1'b0;
   bit           long_hold = 1'b0;

   chroma_key_blend dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic [17:0] root_fix(input logic [35:0] x);
      logic [35:0] rem;
      logic [35:0] r;
      logic [35:0] b;
      rem = x;
      r = '0;
      b = 36'd1 << 34;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r[17:0];
   endfunction

   function automatic logic [8:0] soft_alpha(input logic [40:0] k, input logic [7:0] u,
                                             input logic [7:0] v);
      int du, dv, span, rad, slope, diff, q;
      if (!k[40]) return 9'd0;
      du = int'(k[39:31]) - int'(u);
      dv = int'(k[30:22]) - int'(v);
      if (du < 0) du = -du;
      if (dv < 0) dv = -dv;
      span = root_fix(36'(du * du + dv * dv) << 16);
      rad = int'(k[21:11]) << 5;
      slope = int'(k[10:0]) << 5;
      if (span <= rad) return 9'd256;
      diff = span - rad;
      if (slope == 0 || diff > slope) return 9'd0;
      q = ((diff << 8) + slope - 1) / slope;
      return 9'(256 - q);
   endfunction

   function automatic logic [7:0] blend_px(input logic [7:0] f, input logic [7:0] b,
                                           input logic [8:0] a);
      int unsigned acc;
      acc = f * (256 - a) + b * a;
      return 8'(acc >> 8);
   endfunction

   function automatic blend_t predict_blend(input logic [95:0] d);
      blend_t r;
      logic [8:0] a, ka;
      a = '0;
      for (int i = 0; i < 3; i++) begin
         ka = soft_alpha(key_shadow[i], d[71:64], d[79:72]);
         if (ka > a) a = ka;
      end
      for (int i = 0; i < 4; i++) r.luma[i] = blend_px(d[8*i +: 8], d[32+8*i +: 8], a);
      r.cb = blend_px(d[71:64], d[87:80], a);
      r.cr = blend_px(d[79:72], d[95:88], a);
      r.alpha = a;
      return r;
   endfunction

   function automatic logic [40:0] pack_key(input bit en, input int cu, input int cv,
                                            input int rad, input int slope);
      return {en, 9'(cu), 9'(cv), 11'(rad), 11'(slope)};
   endfunction

   task automatic write_key(input int idx, input logic [40:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= 2'(idx);
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx < 3) key_shadow[idx] = val;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (blend_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // offers one word, held until taken; prediction made at acceptance
   task automatic send_quad(input logic [95:0] d, input bit gaps,
                            input bit known = 1'b0, input logic [63:0] res = '0);
      if (gaps && !calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      blend_queue.push_back(predict_blend(d));
      typed_queue.push_back({known, res});
      words_in++;
      @(negedge clock);
   endtask

   function automatic logic [95:0] rand_quad();
      return {$urandom, $urandom, $urandom};
   endfunction

   // receiver
   initial begin
      int hold;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (200) @(negedge clock);
            long_hold = 1'b0;
         end
         if (!calm && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // checker
   always @(posedge clock) begin
      blend_t got, want;
      logic [64:0] typed_exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         for (int i = 0; i < 4; i++) got.luma[i] = rsp_tdata[8*i +: 8];
         got.cb = rsp_tdata[39:32];
         got.cr = rsp_tdata[47:40];
         got.alpha = rsp_tdata[56:48];
         words_out++;
         if (blend_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            want = blend_queue.pop_front();
            typed_exp = typed_queue.pop_front();
            if (got.alpha == 9'd256) keyed_full++;
            else if (got.alpha != 0) keyed_soft++;
            if (typed_exp[64] && rsp_tdata != typed_exp[63:0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("fixed row: exp %h got %h", typed_exp[63:0], rsp_tdata);
            end
            if (got.luma != want.luma || got.cb != want.cb || got.cr != want.cr ||
                got.alpha != want.alpha) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp l=%h %h %h %h cb=%h cr=%h a=%0d",
                            " got l=%h %h %h %h cb=%h cr=%h a=%0d"},
                           want.luma[0], want.luma[1], want.luma[2], want.luma[3],
                           want.cb, want.cr, want.alpha,
                           got.luma[0], got.luma[1], got.luma[2], got.luma[3],
                           got.cb, got.cr, got.alpha);
            end
         end
      end
   end

   typedef struct {
      logic [95:0] d;
      bit          known;
      logic [63:0] res;
   } row_t;

   initial begin
      row_t rows [$];
      logic [95:0] q;
      logic [63:0] fgpass;
      foreach (key_shadow[i]) key_shadow[i] = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // no key after reset: foreground through, alpha zero
      q = {8'hff, 8'h00, 8'hff, 8'h00, {4{8'h5a}}, 8'h00, 8'hff, 8'h80, 8'h01};
      fgpass = {7'd0, 9'd0, q[79:64], q[31:0]};
      rows.push_back('{q, 1'b1, fgpass});
      rows.push_back('{96'h0, 1'b1, 64'h0});
      rows.push_back('{{96{1'b1}}, 1'b1, {7'd0, 9'd0, 16'hffff, 32'hffffffff}});
      foreach (rows[i]) begin
         send_quad(rows[i].d, 1'b0, rows[i].known, rows[i].res);
      end
      drain();

      // extremes: a wide radius key, a zero radius and slope key, unused index
      write_key(CSR_KEY_ONE, pack_key(1, 0, 0, 2047, 2047));
      write_key(CSR_KEY_TWO, pack_key(1, 511, 511, 0, 0));
      write_key(CSR_KEY_THREE, pack_key(1, 256, 128, 10, 2047));
      write_key(CSR_UNUSED, {41{1'b1}});
      send_quad({8'h00, 8'h00, 8'hff, 8'hff, 32'h00000000, 32'hffffffff}, 1'b0);
      send_quad({8'h12, 8'h34, 8'hff, 8'h00, 32'hffffffff, 32'h00000000}, 1'b0);
      drain();
      // zero slope, soft edge and centre above 256
      write_key(CSR_KEY_ONE, pack_key(1, 128, 128, 80, 0));
      write_key(CSR_KEY_TWO, pack_key(1, 300, 20, 40, 400));
      write_key(CSR_KEY_THREE, pack_key(0, 60, 200, 100, 100));
      for (int i = 0; i < 16; i++) begin
         q = rand_quad();
         q[71:64] = 8'(118 + i * 2); q[79:72] = 8'(128 + i);
         send_quad(q, 1'b0);
      end
      drain();

      // random phases with fresh keys
      for (int ph = 0; ph < 6; ph++) begin
         for (int k = 0; k < 3; k++)
            write_key(k, {$urandom_range(0, 3) != 0, 9'($urandom_range(0, 300)),
                          9'($urandom_range(0, 300)), 11'($urandom_range(0, 800)),
                          11'($urandom_range(0, 2047))});
         if (ph == 5) calm = 1'b1;
         for (int n = 0; n < N_RANDOM / 6; n++) begin
            q = rand_quad();
            // steer chroma near a key most of the time
            if ($urandom_range(0, 3) != 0) begin
               logic [40:0] kk;
               kk = key_shadow[$urandom_range(0, 2)];
               q[71:64] = 8'(int'(kk[39:31]) + int'($urandom_range(0, 80)) - 40);
               q[79:72] = 8'(int'(kk[30:22]) + int'($urandom_range(0, 80)) - 40);
            end
            if (ph == 1 && n == 20) long_hold = 1'b1;
            if (ph == 2 && n == 50) drain();
            send_quad(q, 1'b1);
         end
         drain();
      end

      $display("%0d quads sent, %0d checked; %0d fully keyed, %0d soft keyed",
               words_in, words_out, keyed_full, keyed_soft);
      if (mismatches == 0 && blend_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
